FILE: sv/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted table binary search core.
// ----------------------------------------------------------------------------
package stbs_pkg;

   localparam int SLOT_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int WIN_W      = SLOT_W + 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic KIND_LOAD   = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // register index, taken from paddr[2]
   localparam logic REG_RANGE_FIRST = 1'b0;
   localparam logic REG_RANGE_LAST  = 1'b1;

   localparam logic [SLOT_W-1:0] RANGE_FIRST_RESET = 8'd0;
   localparam logic [SLOT_W-1:0] RANGE_LAST_RESET  = 8'd255;

   typedef struct packed {
      logic                      kind;
      logic [SLOT_W-1:0]         entry_index;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PROBE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // write the incoming entry into the table
      logic start;   // capture key and search window
      logic issue;   // read the table at the window midpoint
      logic step;    // narrow the window by the last probe
      logic finish;  // load the result register
      logic found;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;       // current window is empty
      logic hit;         // probed entry equals key
      logic single;      // current window is one slot
      logic step_empty;  // narrowed window would be empty
   } sts_type;

endpackage

FILE: sv/stbs_csr.sv
// ----------------------------------------------------------------------------
// stbs_csr
// APB register file holding the search window bounds.
// ----------------------------------------------------------------------------
module stbs_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [stbs_pkg::SLOT_W-1:0]         range_first,
   output logic [stbs_pkg::SLOT_W-1:0]         range_last
);

   logic [stbs_pkg::SLOT_W-1:0] first_ff, first_in;
   logic [stbs_pkg::SLOT_W-1:0] last_ff, last_in;
   logic                        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      if (wr_en) begin
         unique case (paddr[2])
            stbs_pkg::REG_RANGE_FIRST: first_in = pwdata[stbs_pkg::SLOT_W-1:0];
            stbs_pkg::REG_RANGE_LAST:  last_in  = pwdata[stbs_pkg::SLOT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         stbs_pkg::REG_RANGE_FIRST: prdata = stbs_pkg::CSR_DATA_W'(first_ff);
         stbs_pkg::REG_RANGE_LAST:  prdata = stbs_pkg::CSR_DATA_W'(last_ff);
         default:                   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= stbs_pkg::RANGE_FIRST_RESET;
         last_ff  <= stbs_pkg::RANGE_LAST_RESET;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
      end
   end

   assign range_first = first_ff;
   assign range_last  = last_ff;

endmodule

FILE: sv/stbs_ctrl.sv
// ----------------------------------------------------------------------------
// stbs_ctrl
// Search sequencer and result valid flag.
// ----------------------------------------------------------------------------
module stbs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_kind,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output stbs_pkg::cmd_type   cmd,
   input  stbs_pkg::sts_type   sts
);

   stbs_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   // result register can take a new result this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == stbs_pkg::KIND_SEARCH) begin
                  cmd.start = 1'b1;
                  state_in  = stbs_pkg::ST_CHECK;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         stbs_pkg::ST_CHECK: begin
            if (sts.empty) begin
               if (out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = stbs_pkg::ST_IDLE;
               end
            end else begin
               cmd.issue = 1'b1;
               state_in  = stbs_pkg::ST_PROBE;
            end
         end
         stbs_pkg::ST_PROBE: begin
            if (sts.hit || sts.single || sts.step_empty) begin
               // hold the probe until the result register frees up
               if (out_free) begin
                  cmd.finish = 1'b1;
                  cmd.found  = sts.hit;
                  state_in   = stbs_pkg::ST_IDLE;
               end
            end else begin
               cmd.step  = 1'b1;
               cmd.issue = 1'b1;
            end
         end
         default: state_in = stbs_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign req_stall    = (state_ff != stbs_pkg::ST_IDLE);

endmodule

FILE: sv/stbs_dpath.sv
// ----------------------------------------------------------------------------
// stbs_dpath
// Table memory, search window registers, probe compare and result register.
// ----------------------------------------------------------------------------
module stbs_dpath #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                          clock,
   input  stbs_pkg::req_type             req_data,
   input  logic [stbs_pkg::SLOT_W-1:0]   range_first,
   input  logic [stbs_pkg::SLOT_W-1:0]   range_last,
   input  stbs_pkg::cmd_type             cmd,
   output stbs_pkg::sts_type             sts,
   output stbs_pkg::rsp_type             rsp_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int XW = (AW > stbs_pkg::SLOT_W) ? AW : stbs_pkg::SLOT_W;
   localparam int SW = stbs_pkg::SLOT_W;
   localparam int WW = stbs_pkg::WIN_W;
   localparam int VW = stbs_pkg::VALUE_W;

   logic [VW-1:0] mem [TABLE_DEPTH];

   logic signed [WW-1:0] lo_ff, lo_in;
   logic signed [WW-1:0] hi_ff, hi_in;
   logic signed [VW-1:0] key_ff;
   logic [SW-1:0]        mid_ff;
   logic [VW-1:0]        rd_mem_ff;
   logic                 rd_oob_ff;
   stbs_pkg::rsp_type    rsp_ff;

   logic [XW-1:0]        wr_ext;
   logic                 wr_ok;
   logic [XW-1:0]        rd_ext;
   logic                 rd_ok;
   logic signed [VW-1:0] probe;
   logic                 key_lt;
   logic signed [WW-1:0] mid_w;
   logic signed [WW-1:0] step_lo, step_hi;
   logic signed [WW-1:0] win_lo, win_hi;
   logic signed [WW-1:0] win_sum;
   logic [SW-1:0]        rd_slot;

   // slots at or above the table depth are dropped on load and read as zero
   assign wr_ext = XW'(req_data.entry_index);
   assign wr_ok  = (TABLE_DEPTH >= 256) || (req_data.entry_index < SW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.load && wr_ok) begin
         mem[wr_ext[AW-1:0]] <= req_data.value;
      end
   end

   // probe compare on the registered read
   assign probe   = rd_oob_ff ? '0 : $signed(rd_mem_ff);
   assign key_lt  = key_ff < probe;
   assign mid_w   = $signed({2'b00, mid_ff});
   assign step_lo = key_lt ? lo_ff : mid_w + 10'sd1;
   assign step_hi = key_lt ? mid_w - 10'sd1 : hi_ff;

   // floor midpoint of the window being probed next
   assign win_lo  = cmd.step ? step_lo : lo_ff;
   assign win_hi  = cmd.step ? step_hi : hi_ff;
   assign win_sum = win_lo + win_hi;
   assign rd_slot = win_sum[SW:1];

   assign rd_ext = XW'(rd_slot);
   assign rd_ok  = (TABLE_DEPTH >= 256) || (rd_slot < SW'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         rd_mem_ff <= mem[rd_ext[AW-1:0]];
         rd_oob_ff <= ~rd_ok;
         mid_ff    <= rd_slot;
      end
   end

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start) begin
         lo_in = $signed({2'b00, range_first});
         hi_in = $signed({2'b00, range_last});
      end else if (cmd.step) begin
         lo_in = step_lo;
         hi_in = step_hi;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.start) begin
         key_ff <= req_data.value;
      end
      if (cmd.finish) begin
         rsp_ff.found <= cmd.found;
         rsp_ff.slot  <= cmd.found ? mid_ff : '0;
      end
   end

   assign sts.empty      = lo_ff > hi_ff;
   assign sts.hit        = key_ff == probe;
   assign sts.single     = lo_ff == hi_ff;
   assign sts.step_empty = step_lo > step_hi;

   assign rsp_data = rsp_ff;

endmodule

FILE: sv/sorted_table_binary_search_core.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Sorted table of signed 32-bit entries with a binary search per key.
// ----------------------------------------------------------------------------
// Input channel req_*: a load transfer (kind 0) writes value into slot
// entry_index and gives no result; a search transfer (kind 1) looks for
// value in slots range_first..range_last and gives one rsp_* transfer with
// found and slot (slot is zero when not found).
// A load is written when it is accepted and the next item is taken right after it.
// A search passes the ST_CHECK setup state, then makes one probe per cycle
// through the registered table read port, the last probe holding while the
// result register is full: at most ceil(log2(range size + 1)) probes.
// req_stall is high while a search runs.
// Results sit in an output register, so a new item is accepted while a
// result waits; a search that finishes while rsp_stall holds the previous
// result waits on its last probe, or in ST_CHECK for an empty window,
// until the register frees. Range registers are written over APB at 0x0
// (first) and 0x4 (last). Reset clears the sequencer and result valid and
// sets the range to 0..255; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_core #(
   parameter int unsigned TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  stbs_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output stbs_pkg::rsp_type                   rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [stbs_pkg::SLOT_W-1:0] range_first;
   logic [stbs_pkg::SLOT_W-1:0] range_last;
   stbs_pkg::cmd_type           cmd;
   stbs_pkg::sts_type           sts;

   stbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .range_first (range_first),
      .range_last  (range_last)
   );

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_data.kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   stbs_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .req_data    (req_data),
      .range_first (range_first),
      .range_last  (range_last),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_data    (rsp_data)
   );

endmodule

FILE: sv/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks for the sorted table binary search core.
// ----------------------------------------------------------------------------
module stbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input stbs_pkg::req_type                   req_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input stbs_pkg::rsp_type                   rsp_data,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata,
   input logic [stbs_pkg::CSR_DATA_W-1:0]     prdata,
   input logic                                pready
);

   // no result comes out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a miss always reports slot zero
   a_miss_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.slot == '0)
      else $error("miss with nonzero slot");

   // a search transfer occupies the block for at least the setup cycle
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == stbs_pkg::KIND_SEARCH |=> req_stall)
      else $error("input taken right after a search transfer");

   // a load transfer leaves the input open
   a_load_open: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.kind == stbs_pkg::KIND_LOAD |=> !req_stall)
      else $error("input stalled after a load transfer");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind sorted_table_binary_search_core stbs_checker u_stbs_checker (.*);

FILE: tb/sorted_table_binary_search_checker.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_checker
// Watches the request, result and APB ports of the search core, keeps its
// own copy of the table and of the search window, predicts each search
// result and compares it with what the core returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  stbs_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  stbs_pkg::rsp_type               rsp_data,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0] pwdata,
   output int                              mismatch_count,
   output int                              pending_count
);

   logic signed [stbs_pkg::VALUE_W-1:0] table_copy [256];
   logic [stbs_pkg::SLOT_W-1:0]         first_slot;
   logic [stbs_pkg::SLOT_W-1:0]         last_slot;
   stbs_pkg::rsp_type                   expected_results [$];

   // halving search over first_slot..last_slot, floor midpoint each round
   function automatic stbs_pkg::rsp_type lookup_key(
      input logic signed [stbs_pkg::VALUE_W-1:0] key
   );
      stbs_pkg::rsp_type                   res;
      int                                  lo;
      int                                  hi;
      int                                  mid;
      logic signed [stbs_pkg::VALUE_W-1:0] probe;
      res = '0;
      lo  = first_slot;
      hi  = last_slot;
      while (lo <= hi) begin
         mid   = (lo + hi) / 2;
         probe = table_copy[mid];
         if (key == probe) begin
            res.found = 1'b1;
            res.slot  = stbs_pkg::SLOT_W'(mid);
            break;
         end
         // a one-slot window that misses ends the search
         if (lo == hi) break;
         if (key < probe) hi = mid - 1;
         else lo = mid + 1;
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      stbs_pkg::rsp_type want;
      if (reset) begin
         first_slot     = stbs_pkg::RANGE_FIRST_RESET;
         last_slot      = stbs_pkg::RANGE_LAST_RESET;
         mismatch_count = 0;
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == stbs_pkg::REG_RANGE_FIRST) first_slot = pwdata[stbs_pkg::SLOT_W-1:0];
            else last_slot = pwdata[stbs_pkg::SLOT_W-1:0];
         end
         if (req_valid && !req_stall) begin
            if (req_data.kind == stbs_pkg::KIND_LOAD) begin
               table_copy[req_data.entry_index] = req_data.value;
            end else begin
               expected_results.push_back(lookup_key(req_data.value));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, got found=%0b slot=%0d",
                        $time, rsp_data.found, rsp_data.slot);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, got %0b",
                           $time, want.found, rsp_data.found);
                  mismatch_count++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $display("%0t: slot mismatch: expected %0d, got %0d",
                           $time, want.slot, rsp_data.slot);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count <= expected_results.size();
   end

endmodule

FILE: tb/sorted_table_binary_search_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core_tb
// Fills the table with sorted entries, runs directed searches over the
// window extremes and an out-of-order entry, then phases of random loads
// and searches under several window settings with random idle and stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_binary_search_core_tb;

   localparam int VAL_MIN      = 32'sh8000_0000;
   localparam int VAL_MAX      = 32'sh7fff_ffff;
   localparam int WIDE_STEP    = 24'hff_ffff;
   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 30;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   stbs_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   stbs_pkg::rsp_type               rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [stbs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [stbs_pkg::CSR_DATA_W-1:0] pwdata;
   logic [stbs_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   int                              mismatch_count;
   int                              pending_count;
   int                              quiet_cycles;
   bit                              no_idle;
   int                              table_img [256];
   logic [stbs_pkg::SLOT_W-1:0]     win_first;
   logic [stbs_pkg::SLOT_W-1:0]     win_last;

   sorted_table_binary_search_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   sorted_table_binary_search_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .pready         (pready),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 16);
   end

   // ends the run when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic kind, input logic [stbs_pkg::SLOT_W-1:0] idx,
                            input int val);
      stbs_pkg::req_type item;
      item.kind        = kind;
      item.entry_index = idx;
      item.value       = val;
      while (!no_idle && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic load_entry(input logic [stbs_pkg::SLOT_W-1:0] idx, input int val);
      table_img[idx] = val;
      send_item(stbs_pkg::KIND_LOAD, idx, val);
   endtask

   task automatic search_key(input int key);
      send_item(stbs_pkg::KIND_SEARCH, stbs_pkg::SLOT_W'($urandom), key);
   endtask

   // hold off new requests until every search result has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [stbs_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [stbs_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      forever begin
         @(posedge clock);
         if (pready) break;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_window(input logic [stbs_pkg::SLOT_W-1:0] first,
                             input logic [stbs_pkg::SLOT_W-1:0] last);
      drain();
      // upper data bits are junk, only the low byte is kept
      csr_write({stbs_pkg::REG_RANGE_FIRST, 2'b00}, {24'($urandom), first});
      csr_write({stbs_pkg::REG_RANGE_LAST, 2'b00}, {24'($urandom), last});
      win_first = first;
      win_last  = last;
   endtask

   // ascending entries from the most negative value up
   task automatic fill_table(input int max_step, input bit reach_top);
      longint v;
      int     s;
      v = VAL_MIN;
      for (s = 0; s < 256; s++) begin
         if (reach_top && s == 255) v = VAL_MAX;
         load_entry(stbs_pkg::SLOT_W'(s), int'(v));
         v += $urandom_range(0, max_step);
      end
   endtask

   task automatic random_item();
      int              pick;
      int              s;
      longint          lo_v;
      longint          hi_v;
      longint unsigned span;
      longint unsigned r;
      pick = $urandom_range(0, 99);
      if (win_first <= win_last) s = $urandom_range(win_first, win_last);
      else s = $urandom_range(0, 255);
      if (pick < 12) begin
         // rewrite one entry between its neighbors so the table stays sorted
         s    = $urandom_range(0, 255);
         lo_v = (s == 0) ? longint'(VAL_MIN) : longint'(table_img[s-1]);
         hi_v = (s == 255) ? longint'(VAL_MAX) : longint'(table_img[s+1]);
         if (lo_v > hi_v) hi_v = lo_v;
         span = hi_v - lo_v + 1;
         r    = {$urandom, $urandom};
         load_entry(stbs_pkg::SLOT_W'(s), int'(lo_v + longint'(r % span)));
      end else if (pick < 15) begin
         load_entry(stbs_pkg::SLOT_W'($urandom), int'($urandom));
      end else if (pick < 65) begin
         search_key(table_img[s]);
      end else if (pick < 85) begin
         search_key($urandom_range(0, 1) ? table_img[s] + 1 : table_img[s] - 1);
      end else begin
         search_key(int'($urandom));
      end
   endtask

   initial begin : stimulus
      int                          saved;
      int                          ph;
      logic [stbs_pkg::SLOT_W-1:0] first;
      logic [stbs_pkg::SLOT_W-1:0] last;
      no_idle   = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      win_first = stbs_pkg::RANGE_FIRST_RESET;
      win_last  = stbs_pkg::RANGE_LAST_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fill_table(WIDE_STEP, 1'b1);

      // full window: both value extremes, the ends and the middle
      search_key(VAL_MIN);
      search_key(VAL_MAX);
      search_key(table_img[1]);
      search_key(table_img[127]);
      search_key(table_img[128]);
      search_key(table_img[254]);
      search_key(table_img[100] + 1);
      search_key(int'($urandom));

      // empty window
      set_window(8'd200, 8'd10);
      search_key(table_img[150]);

      // one-slot windows at both ends, hit and miss
      set_window(8'd0, 8'd0);
      search_key(table_img[0]);
      search_key(table_img[0] - 1);
      set_window(8'd255, 8'd255);
      search_key(VAL_MAX);
      search_key(0);

      // out-of-order entry in the middle of the table
      set_window(8'd0, 8'd255);
      saved = table_img[128];
      load_entry(8'd128, VAL_MAX);
      search_key(table_img[200]);
      search_key(table_img[60]);
      search_key(VAL_MAX);
      load_entry(8'd128, saved);

      for (ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               first = 8'd0;
               last  = 8'd255;
            end
            1: begin
               first = 8'd255;
               last  = 8'd255;
            end
            2: begin
               first = 8'd0;
               last  = 8'd0;
            end
            3: begin
               first = stbs_pkg::SLOT_W'($urandom_range(1, 255));
               last  = stbs_pkg::SLOT_W'($urandom_range(0, first - 1));
            end
            default: begin
               first = stbs_pkg::SLOT_W'($urandom_range(0, 255));
               last  = stbs_pkg::SLOT_W'($urandom_range(first, 255));
            end
         endcase
         set_window(first, last);
         // dense table with many repeated entries, later a wide one again
         if (ph == 4) fill_table(3, 1'b0);
         if (ph == 6) fill_table(WIDE_STEP, 1'b1);
         no_idle = (ph == 5);
         repeat (PHASE_ITEMS) random_item();
      end
      no_idle = 1'b0;
      drain();

      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/stbs_pkg.sv
sv/stbs_csr.sv
sv/stbs_ctrl.sv
sv/stbs_dpath.sv
sv/sorted_table_binary_search_core.sv
sv/stbs_checker.sv
tb/sorted_table_binary_search_checker.sv
tb/sorted_table_binary_search_core_tb.sv
